/* hdl/tce_pkg.sv */
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types, constants and arithmetic helpers of the tiltrotor control
// effectiveness block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

  // Number of CORDIC cells per chain and of square root cells.
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned SQRT_STEPS   = 24;
  localparam int unsigned NUM_LANES    = 4;

  typedef logic signed [15:0] s16_t;
  typedef logic signed [31:0] q16_t;
  typedef logic signed [33:0] trig_t;
  typedef logic signed [20:0] ang_t;

  // Angle constants in Q.16 radians, CORDIC start value in Q2.30.
  localparam ang_t  PI16     = 21'sd205887;
  localparam ang_t  HALFPI16 = 21'sd102944;
  localparam ang_t  TWOPI16  = 21'sd411775;
  localparam trig_t K_START  = 34'sd652032874;

  localparam ang_t ARC_TAB [CORDIC_STEPS] = '{
    21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150, 21'sd4091, 21'sd2047,
    21'sd1024, 21'sd512, 21'sd256, 21'sd128, 21'sd64, 21'sd32, 21'sd16,
    21'sd8, 21'sd4, 21'sd2
  };

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LIFT_GAIN  = 2'd0,
    CFG_COEFF_ZERO = 2'd1,
    CFG_COEFF_SLOPE = 2'd2,
    CFG_MIN_SPEED  = 2'd3
  } cfg_idx_e;

  // Earth axis of a result row.
  typedef enum logic [1:0] {
    AXIS_NORTH = 2'd0,
    AXIS_EAST  = 2'd1,
    AXIS_DOWN  = 2'd2
  } axis_e;

  // Input beat, first field in the highest bits.
  typedef struct packed {
    q16_t err_down;
    q16_t err_east;
    q16_t err_north;
    s16_t vel_down;
    s16_t vel_east;
    s16_t vel_north;
    q16_t thrust_vert;
    q16_t thrust_fwd;
    s16_t yaw_angle;
    s16_t pitch_angle;
    s16_t roll_angle;
  } item_t;

  // Output beat payload without the last-row flag.
  typedef struct packed {
    q16_t        objective;
    q16_t        d_fwd_thrust;
    q16_t        d_vert_thrust;
    q16_t        d_pitch;
    q16_t        d_roll;
    logic [1:0]  row_axis;
  } row_t;

  // Square root cell state: radicand still to consume, remainder, root.
  typedef struct packed {
    logic [47:0] rad;
    logic [25:0] rem;
    logic [23:0] root;
  } sqrt_t;

  // Vectoring CORDIC cell state.
  typedef struct packed {
    logic signed [27:0] x;
    logic signed [27:0] y;
    logic signed [19:0] z;
  } vec_t;

  // Rotation CORDIC lane state.
  typedef struct packed {
    trig_t x;
    trig_t y;
    ang_t  z;
  } rot_lane_t;

  typedef rot_lane_t [NUM_LANES-1:0] rot_set_t;

  // Data riding along the square root and vectoring chains.
  typedef struct packed {
    item_t       it;
    logic [39:0] q;
    logic        slow;
  } sq_side_t;

  // Data riding along the rotation chain.
  typedef struct packed {
    item_t                it;
    q16_t                 l1;
    logic                 slow;
    logic [NUM_LANES-1:0] flip;
  } rot_side_t;

  typedef struct packed {
    ang_t z;
    logic flip;
  } prep_t;

  // Round to nearest by n bits, ties toward plus infinity.
  function automatic logic signed [67:0] rnd(input logic signed [67:0] v,
                                             input int unsigned n);
    return (v + (68'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Clamp to the signed 32 bit range.
  function automatic q16_t sat32(input logic signed [67:0] v);
    q16_t r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = q16_t'(v);
    end
    return r;
  endfunction

  // Q2.30 product with rounding.
  function automatic trig_t mul30(input trig_t a, input trig_t b);
    logic signed [67:0] p;
    p = rnd(68'(a) * 68'(b), 30);
    return trig_t'(p);
  endfunction

  // Wrap an angle into one turn and fold it into the right half plane.
  function automatic prep_t prep_angle(input ang_t a);
    ang_t z;
    logic f;
    z = a;
    f = 1'b0;
    if (z > PI16) z = z - TWOPI16;
    if (z < -PI16) z = z + TWOPI16;
    if (z > HALFPI16) begin
      z = z - PI16;
      f = 1'b1;
    end else if (z < -HALFPI16) begin
      z = z + PI16;
      f = 1'b1;
    end
    return '{z: z, flip: f};
  endfunction

endpackage

`default_nettype wire

/* hdl/tce_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// tce_sqrt_cell
// One digit of a restoring integer square root; consumes two radicand bits
// and produces one root bit per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tce_sqrt_cell #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  tce_pkg::sqrt_t    d_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output tce_pkg::sqrt_t    d_o,
  output logic [SIDE_W-1:0] side_o
);
  import tce_pkg::*;

  logic              vld_q;
  sqrt_t             d_q, d_d;
  logic [SIDE_W-1:0] side_q;
  logic [27:0]       rem_n;
  logic [27:0]       trial;

  // Bring down two bits and try to subtract the trial divisor.
  always_comb begin
    rem_n = {d_i.rem, d_i.rad[47:46]};
    trial = {2'b00, d_i.root, 2'b01};
    d_d.rad = {d_i.rad[45:0], 2'b00};
    if (rem_n >= trial) begin
      d_d.rem  = 26'(rem_n - trial);
      d_d.root = {d_i.root[22:0], 1'b1};
    end else begin
      d_d.rem  = 26'(rem_n);
      d_d.root = {d_i.root[22:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q    <= d_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign d_o    = d_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

/* hdl/tce_vec_cell.sv */
// ----------------------------------------------------------------------------
// tce_vec_cell
// One vectoring CORDIC micro-rotation toward the x axis, accumulating the
// flight path angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tce_vec_cell #(
  parameter int unsigned STEP   = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  tce_pkg::vec_t     d_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output tce_pkg::vec_t     d_o,
  output logic [SIDE_W-1:0] side_o
);
  import tce_pkg::*;

  logic              vld_q;
  vec_t              d_q, d_d;
  logic [SIDE_W-1:0] side_q;

  // Rotate against the sign of y.
  always_comb begin
    if (d_i.y > 0) begin
      d_d.x = d_i.x + (d_i.y >>> STEP);
      d_d.y = d_i.y - (d_i.x >>> STEP);
      d_d.z = d_i.z + 20'(ARC_TAB[STEP]);
    end else begin
      d_d.x = d_i.x - (d_i.y >>> STEP);
      d_d.y = d_i.y + (d_i.x >>> STEP);
      d_d.z = d_i.z - 20'(ARC_TAB[STEP]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q    <= d_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign d_o    = d_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

/* hdl/tce_rot_cell.sv */
// ----------------------------------------------------------------------------
// tce_rot_cell
// One rotation CORDIC micro-rotation applied to four angle lanes at once
// (roll, pitch, heading, angle of attack).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tce_rot_cell #(
  parameter int unsigned STEP   = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  tce_pkg::rot_set_t d_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output tce_pkg::rot_set_t d_o,
  output logic [SIDE_W-1:0] side_o
);
  import tce_pkg::*;

  logic              vld_q;
  rot_set_t          d_q, d_d;
  logic [SIDE_W-1:0] side_q;

  // Drive each residual angle toward zero.
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      if (d_i[k].z >= 0) begin
        d_d[k].x = d_i[k].x - (d_i[k].y >>> STEP);
        d_d[k].y = d_i[k].y + (d_i[k].x >>> STEP);
        d_d[k].z = d_i[k].z - ARC_TAB[STEP];
      end else begin
        d_d[k].x = d_i[k].x + (d_i[k].y >>> STEP);
        d_d[k].y = d_i[k].y - (d_i[k].x >>> STEP);
        d_d[k].z = d_i[k].z + ARC_TAB[STEP];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q    <= d_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign d_o    = d_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

/* hdl/tiltrotor_control_effectiveness_top.sv */
// ----------------------------------------------------------------------------
// tiltrotor_control_effectiveness_top
// Wing lift estimate and per-axis control effectiveness rows for a tiltrotor.
//
//  Channel  Direction  Beat
//  s_axis   in         one attitude/thrust/velocity/error item (256 bits)
//  m_axis   out        one effectiveness row; three per item, tlast on down
//  cfg      in         register write, index and data, no handshake
//
// A fully pipelined chain of cells (24 square root, 16 vectoring CORDIC,
// 16 four-lane rotation CORDIC, plus arithmetic stages) takes one item per
// cycle unless a stalled output freezes it; the three output beats per item
// limit the sustained rate. Reset clears all valid flags and the registers
// to their reset values. A stalled output freezes the whole chain only
// when its last stage holds an item; bubbles keep moving and new items
// are taken meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tiltrotor_control_effectiveness_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // roll, pitch, yaw, thrust_fwd, thrust_vert, vel_north, vel_east,
  // vel_down, err_north, err_east, err_down
  input  logic [255:0] s_axis_tdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // row_axis, d_roll, d_pitch, d_vert_thrust, d_fwd_thrust, objective, pad
  output logic [167:0] m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic         m_axis_tlast_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i
);
  import tce_pkg::*;

  localparam int unsigned SQ_SIDE_W  = $bits(sq_side_t);
  localparam int unsigned ROT_SIDE_W = $bits(rot_side_t);

  // Configuration registers.
  logic [23:0] gain_q;
  s16_t        c0_q;
  s16_t        slope_q;
  logic [15:0] vmin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= '0;
      c0_q    <= '0;
      slope_q <= '0;
      vmin_q  <= 16'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LIFT_GAIN:   gain_q  <= cfg_data_i;
        CFG_COEFF_ZERO:  c0_q    <= cfg_data_i[15:0];
        CFG_COEFF_SLOPE: slope_q <= cfg_data_i[15:0];
        CFG_MIN_SPEED:   vmin_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Chain control.
  logic  pipe_en;
  logic  hold_full_q;
  axis_e row_q;
  logic  out_done;
  logic  i_vld_q;

  assign out_done        = hold_full_q && m_axis_tready_i && (row_q == AXIS_DOWN);
  assign pipe_en         = !i_vld_q || !hold_full_q || out_done;
  assign s_axis_tready_o = pipe_en;

  // Stage valids.
  logic v0_q, v1_q, v2_q, va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q;
  logic sq_vld  [SQRT_STEPS+1];
  logic vec_vld [CORDIC_STEPS+1];
  logic rot_vld [CORDIC_STEPS+1];

  // Input and speed stages.
  item_t       it0_q, it1_q;
  logic [31:0] h2_q, v2sq_q;
  logic [31:0] h2_d, v2sq_d;
  logic signed [31:0] sqn, sqe, sqd;
  logic [55:0] qp;

  always_comb begin
    sqn    = it0_q.vel_north * it0_q.vel_north;
    sqe    = it0_q.vel_east * it0_q.vel_east;
    sqd    = it0_q.vel_down * it0_q.vel_down;
    h2_d   = {1'b0, sqn[30:0]} + {1'b0, sqe[30:0]};
    v2sq_d = h2_d + {1'b0, sqd[30:0]};
    qp     = 56'(gain_q) * 56'(v2sq_q) + 56'd32768;
  end

  // Square root chain.
  sqrt_t                sq_d    [SQRT_STEPS+1];
  logic [SQ_SIDE_W-1:0] sq_side [SQRT_STEPS+1];
  sq_side_t             s2_side;

  always_comb begin
    s2_side.it   = it1_q;
    s2_side.q    = qp[55:16];
    s2_side.slow = v2sq_q <= 32'(vmin_q * vmin_q);
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    tce_sqrt_cell #(.SIDE_W(SQ_SIDE_W)) u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (pipe_en),
      .vld_i (sq_vld[g]), .d_i (sq_d[g]), .side_i (sq_side[g]),
      .vld_o (sq_vld[g+1]), .d_o (sq_d[g+1]), .side_o (sq_side[g+1])
    );
  end

  // Vectoring chain for the flight path angle.
  vec_t                 vec_d    [CORDIC_STEPS+1];
  logic [SQ_SIDE_W-1:0] vec_side [CORDIC_STEPS+1];
  sq_side_t             sq_out;

  always_comb begin
    sq_out     = sq_side_t'(sq_side[SQRT_STEPS]);
    vec_d[0].x = $signed({4'b0000, sq_d[SQRT_STEPS].root});
    vec_d[0].y = -(28'(sq_out.it.vel_down) <<< 8);
    vec_d[0].z = '0;
  end
  assign vec_vld[0]  = sq_vld[SQRT_STEPS];
  assign vec_side[0] = sq_side[SQRT_STEPS];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    tce_vec_cell #(.STEP(g), .SIDE_W(SQ_SIDE_W)) u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (pipe_en),
      .vld_i (vec_vld[g]), .d_i (vec_d[g]), .side_i (vec_side[g]),
      .vld_o (vec_vld[g+1]), .d_o (vec_d[g+1]), .side_o (vec_side[g+1])
    );
  end

  // Angle of attack, lift coefficient and dynamic pressure product.
  sq_side_t           vec_out, a_side_q, b_side_q, c_side_q;
  ang_t               alpha_d, alpha_q;
  logic signed [36:0] clp_q;
  logic signed [22:0] cl_q;
  prep_t              prep_q [NUM_LANES];
  logic signed [43:0] pl_q, ph_q;
  prep_t              prepc_q [NUM_LANES];
  logic signed [67:0] lsum;

  always_comb begin
    vec_out = sq_side_t'(vec_side[CORDIC_STEPS]);
    alpha_d = 21'(vec_d[CORDIC_STEPS].z) - (21'(vec_out.it.pitch_angle) <<< 3);
    lsum    = (68'(ph_q) <<< 20) + 68'(pl_q);
  end

  // Rotation chain for all four sines and cosines.
  rot_set_t              rot_d    [CORDIC_STEPS+1];
  logic [ROT_SIDE_W-1:0] rot_side [CORDIC_STEPS+1];
  rot_set_t              rot_init_q;
  rot_side_t             rot_side_init_q;

  assign rot_d[0]    = rot_init_q;
  assign rot_side[0] = rot_side_init_q;
  assign rot_vld[0]  = vd_q;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    tce_rot_cell #(.STEP(g), .SIDE_W(ROT_SIDE_W)) u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (pipe_en),
      .vld_i (rot_vld[g]), .d_i (rot_d[g]), .side_i (rot_side[g]),
      .vld_o (rot_vld[g+1]), .d_o (rot_d[g+1]), .side_o (rot_side[g+1])
    );
  end

  // Trig stages.
  rot_side_t rot_out;
  item_t     ite_q, itf_q, itg_q;
  q16_t      l1e_q;
  logic      slowe_q, slowf_q;
  trig_t     sr_q, cr_q, sp_q, cp_q, sy_q, cy_q, ca_q;
  trig_t     syf_q, cyf_q;
  trig_t     a_cpsr_q, a_spsr_q, a_spcr_q, a_cpcr_q;
  trig_t     a_spcy_q, a_spsy_q, a_cpcy_q, a_cpsy_q;
  logic signed [39:0] lp_q;
  trig_t     b_cpsrsy_q, b_cpsrcy_q, b_spsrsy_q, b_spsrcy_q;
  trig_t     b_spcrsy_q, b_cpcrsy_q, b_spcrcy_q, b_cpcrcy_q;
  trig_t     g_spcy_q, g_spsy_q, g_cpcr_q, g_cpcy_q, g_cpsy_q, g_spcr_q;
  trig_t     g_spsr_q, g_cpsr_q;
  q16_t      up_g_q, up_h_q, up_i_q;
  q16_t      lift_g;
  q16_t      fwd_h_q, fwd_i_q;
  q16_t      err_h_q [3];
  q16_t      err_i_q [3];
  trig_t     rf_q [3];
  trig_t     ru_q [3];
  trig_t     tz_q [3];
  trig_t     tx_q [3];
  logic signed [35:0] fa_q [3];
  logic signed [35:0] ua_q [3];
  logic signed [35:0] pf_q [3];
  logic signed [35:0] pu_q [3];
  q16_t      dv_q [3];
  q16_t      df_q [3];

  assign rot_out = rot_side_t'(rot_side[CORDIC_STEPS]);

  always_comb begin
    lift_g = vf_q && slowf_q ? '0 : sat32(-68'(lp_q));
    if (slowf_q) lift_g = '0;
  end

  // Valid flags of the arithmetic stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      vd_q    <= 1'b0;
      ve_q    <= 1'b0;
      vf_q    <= 1'b0;
      vg_q    <= 1'b0;
      vh_q    <= 1'b0;
      i_vld_q <= 1'b0;
    end else if (pipe_en) begin
      v0_q    <= s_axis_tvalid_i;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      va_q    <= vec_vld[CORDIC_STEPS];
      vb_q    <= va_q;
      vc_q    <= vb_q;
      vd_q    <= vc_q;
      ve_q    <= rot_vld[CORDIC_STEPS];
      vf_q    <= ve_q;
      vg_q    <= vf_q;
      vh_q    <= vg_q;
      i_vld_q <= vh_q;
    end
  end

  assign sq_vld[0] = v2_q;

  // Payload of the arithmetic stages.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      // Input and squared speeds.
      it0_q  <= item_t'(s_axis_tdata_i);
      it1_q  <= it0_q;
      h2_q   <= h2_d;
      v2sq_q <= v2sq_d;
      // Square root seed and side data.
      sq_d[0]    <= '{rad: {h2_q, 16'h0000}, rem: '0, root: '0};
      sq_side[0] <= s2_side;
      // Angle of attack and slope product.
      a_side_q <= vec_out;
      alpha_q  <= alpha_d;
      clp_q    <= 37'(slope_q) * 37'(alpha_d);
      // Lift coefficient and angle folding.
      b_side_q <= a_side_q;
      cl_q     <= 23'(c0_q) + 23'((clp_q + 37'sd32768) >>> 16);
      prep_q[0] <= prep_angle(21'(a_side_q.it.roll_angle) <<< 3);
      prep_q[1] <= prep_angle(21'(a_side_q.it.pitch_angle) <<< 3);
      prep_q[2] <= prep_angle(21'(a_side_q.it.yaw_angle) <<< 3);
      prep_q[3] <= prep_angle(alpha_q);
      // Dynamic pressure times lift coefficient, split in two halves.
      c_side_q <= b_side_q;
      pl_q     <= 44'($signed({1'b0, b_side_q.q[19:0]})) * 44'(cl_q);
      ph_q     <= 44'($signed({1'b0, b_side_q.q[39:20]})) * 44'(cl_q);
      prepc_q  <= prep_q;
      // Rotation seeds.
      for (int k = 0; k < NUM_LANES; k++) begin
        rot_init_q[k].x         <= K_START;
        rot_init_q[k].y         <= '0;
        rot_init_q[k].z         <= prepc_q[k].z;
        rot_side_init_q.flip[k] <= prepc_q[k].flip;
      end
      rot_side_init_q.it   <= c_side_q.it;
      rot_side_init_q.slow <= c_side_q.slow;
      rot_side_init_q.l1   <= sat32(rnd(lsum, 12));
      // Quadrant correction of sines and cosines.
      ite_q   <= rot_out.it;
      l1e_q   <= rot_out.l1;
      slowe_q <= rot_out.slow;
      sr_q <= rot_out.flip[0] ? -rot_d[CORDIC_STEPS][0].y : rot_d[CORDIC_STEPS][0].y;
      cr_q <= rot_out.flip[0] ? -rot_d[CORDIC_STEPS][0].x : rot_d[CORDIC_STEPS][0].x;
      sp_q <= rot_out.flip[1] ? -rot_d[CORDIC_STEPS][1].y : rot_d[CORDIC_STEPS][1].y;
      cp_q <= rot_out.flip[1] ? -rot_d[CORDIC_STEPS][1].x : rot_d[CORDIC_STEPS][1].x;
      sy_q <= rot_out.flip[2] ? -rot_d[CORDIC_STEPS][2].y : rot_d[CORDIC_STEPS][2].y;
      cy_q <= rot_out.flip[2] ? -rot_d[CORDIC_STEPS][2].x : rot_d[CORDIC_STEPS][2].x;
      ca_q <= rot_out.flip[3] ? -rot_d[CORDIC_STEPS][3].x : rot_d[CORDIC_STEPS][3].x;
      // First level trig products and lift.
      itf_q    <= ite_q;
      slowf_q  <= slowe_q;
      syf_q    <= sy_q;
      cyf_q    <= cy_q;
      a_cpsr_q <= mul30(cp_q, sr_q);
      a_spsr_q <= mul30(sp_q, sr_q);
      a_spcr_q <= mul30(sp_q, cr_q);
      a_cpcr_q <= mul30(cp_q, cr_q);
      a_spcy_q <= mul30(sp_q, cy_q);
      a_spsy_q <= mul30(sp_q, sy_q);
      a_cpcy_q <= mul30(cp_q, cy_q);
      a_cpsy_q <= mul30(cp_q, sy_q);
      lp_q     <= 40'(rnd(68'(l1e_q) * 68'(ca_q), 30));
      // Second level products and vertical force.
      itg_q      <= itf_q;
      up_g_q     <= sat32(68'(itf_q.thrust_vert) + 68'(lift_g));
      b_cpsrsy_q <= mul30(a_cpsr_q, syf_q);
      b_cpsrcy_q <= mul30(a_cpsr_q, cyf_q);
      b_spsrsy_q <= mul30(a_spsr_q, syf_q);
      b_spsrcy_q <= mul30(a_spsr_q, cyf_q);
      b_spcrsy_q <= mul30(a_spcr_q, syf_q);
      b_cpcrsy_q <= mul30(a_cpcr_q, syf_q);
      b_spcrcy_q <= mul30(a_spcr_q, cyf_q);
      b_cpcrcy_q <= mul30(a_cpcr_q, cyf_q);
      g_spcy_q   <= a_spcy_q;
      g_spsy_q   <= a_spsy_q;
      g_cpcr_q   <= a_cpcr_q;
      g_cpcy_q   <= a_cpcy_q;
      g_cpsy_q   <= a_cpsy_q;
      g_spcr_q   <= a_spcr_q;
      g_spsr_q   <= a_spsr_q;
      g_cpsr_q   <= a_cpsr_q;
      // Thrust directions and roll coefficients per axis.
      fwd_h_q    <= itg_q.thrust_fwd;
      up_h_q     <= up_g_q;
      err_h_q[0] <= itg_q.err_north;
      err_h_q[1] <= itg_q.err_east;
      err_h_q[2] <= itg_q.err_down;
      tz_q[0] <= b_cpsrsy_q + g_spcy_q;
      tz_q[1] <= -b_cpsrcy_q + g_spsy_q;
      tz_q[2] <= g_cpcr_q;
      tx_q[0] <= -b_spsrsy_q + g_cpcy_q;
      tx_q[1] <= b_spsrcy_q + g_cpsy_q;
      tx_q[2] <= -g_spcr_q;
      rf_q[0] <= -b_spcrsy_q;
      ru_q[0] <= b_cpcrsy_q;
      rf_q[1] <= b_spcrcy_q;
      ru_q[1] <= -b_cpcrcy_q;
      rf_q[2] <= g_spsr_q;
      ru_q[2] <= -g_cpsr_q;
      // Force times coefficient terms.
      fwd_i_q <= fwd_h_q;
      up_i_q  <= up_h_q;
      for (int k = 0; k < 3; k++) begin
        err_i_q[k] <= err_h_q[k];
        fa_q[k] <= 36'(rnd(68'(fwd_h_q) * 68'(rf_q[k]), 30));
        ua_q[k] <= 36'(rnd(68'(up_h_q) * 68'(ru_q[k]), 30));
        pf_q[k] <= 36'(rnd(68'(fwd_h_q) * -68'(tz_q[k]), 30));
        pu_q[k] <= 36'(rnd(68'(up_h_q) * 68'(tx_q[k]), 30));
        dv_q[k] <= sat32(rnd(68'(tz_q[k]), 14));
        df_q[k] <= sat32(rnd(68'(tx_q[k]), 14));
      end
    end
  end

  // Final sums feed the output holding register.
  row_t rows_d [3];
  row_t hold_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rows_d[k].row_axis      = 2'(k);
      rows_d[k].d_roll        = sat32(68'(fa_q[k]) + 68'(ua_q[k]));
      rows_d[k].d_pitch       = sat32(68'(pf_q[k]) + 68'(pu_q[k]));
      rows_d[k].d_vert_thrust = dv_q[k];
      rows_d[k].d_fwd_thrust  = df_q[k];
      rows_d[k].objective     = err_i_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && i_vld_q) begin
      hold_q <= rows_d;
    end
  end

  // Output row sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_full_q <= 1'b0;
      row_q       <= AXIS_NORTH;
    end else begin
      if (pipe_en && i_vld_q) begin
        hold_full_q <= 1'b1;
        row_q       <= AXIS_NORTH;
      end else if (out_done) begin
        hold_full_q <= 1'b0;
        row_q       <= AXIS_NORTH;
      end else if (hold_full_q && m_axis_tready_i) begin
        row_q <= axis_e'(row_q + 2'd1);
      end
    end
  end

  assign m_axis_tvalid_o = hold_full_q;
  assign m_axis_tlast_o  = (row_q == AXIS_DOWN);
  assign m_axis_tdata_o  = {6'b000000, hold_q[row_q]};

  // Unused by design: fwd and up of the last stage are folded into terms.
  logic unused_ok;
  assign unused_ok = ^{fwd_i_q, up_i_q};

  // A stalled output beat keeps its row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_full_q && !m_axis_tready_i |=> hold_full_q && $stable(row_q))
    else $error("output row changed while stalled");

  // An empty holding register always restarts at the north row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hold_full_q |-> row_q == AXIS_NORTH)
    else $error("row counter not at north while empty");

  // The last chain stage never drops an item while frozen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    i_vld_q && !pipe_en |=> i_vld_q)
    else $error("last stage item lost during stall");

  // After the last row leaves with nothing behind it, the output goes idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_done && !i_vld_q |=> !m_axis_tvalid_o)
    else $error("output valid after final row");

endmodule

`default_nettype wire
